// ===== design/idd_pkg.sv =====
// idd_pkg: shared types and constants of the isotropic diffusion denoiser
// sample format, action codes, register map and reset values
// no dependencies
package idd_pkg;

    localparam int SAMPLE_W   = 18;   // signed, 8 fraction bits
    localparam int FRAC_W     = 8;
    localparam int PIX_W      = 8;
    localparam int GAIN_W     = 16;   // unsigned 0.16
    localparam int GAIN_SHIFT = 16;
    localparam int CNT_W      = 16;
    localparam int DIM_CFG_W  = 9;
    localparam int LAP_W      = SAMPLE_W + 3;
    localparam int PROD_W     = LAP_W + GAIN_W + 1;
    localparam int CENTER_SHIFT = 2;  // four neighbors: center weighted by 4

    localparam int ACT_W = 2;
    localparam logic [ACT_W-1:0] ACT_LOAD = 2'd0;
    localparam logic [ACT_W-1:0] ACT_RUN  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ = 2'd2;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;
    localparam logic [1:0] REG_GAIN   = 2'd0;
    localparam logic [1:0] REG_PASSES = 2'd1;
    localparam logic [1:0] REG_WIDTH  = 2'd2;
    localparam logic [1:0] REG_HEIGHT = 2'd3;

    localparam logic [GAIN_W-1:0]    RST_GAIN   = 16'd6554;
    localparam logic [CNT_W-1:0]     RST_PASSES = 16'd1;
    localparam logic [DIM_CFG_W-1:0] RST_WIDTH  = 9'd256;
    localparam logic [DIM_CFG_W-1:0] RST_HEIGHT = 9'd256;

    typedef struct packed {
        logic busy;
        logic done;
    } idd_eng_stat_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             status;
        logic             last;
    } idd_result_t;

endpackage

// ===== design/idd_ram.sv =====
// idd_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module idd_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/idd_engine.sv =====
// idd_engine: diffusion pass sequencer; walks the interior of the frame store
// keeps the old previous row in its own ram; uses idd_pkg and idd_ram
module idd_engine #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   start,
    input  logic [idd_pkg::GAIN_W-1:0]             gain,
    input  logic [idd_pkg::CNT_W-1:0]              passes,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]         width,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]        height,
    output idd_pkg::idd_eng_stat_t                 stat,
    output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] frame_raddr,
    input  logic [idd_pkg::SAMPLE_W-1:0]           frame_rdata,
    output logic                                   frame_we,
    output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] frame_waddr,
    output logic [idd_pkg::SAMPLE_W-1:0]           frame_wdata
);
    import idd_pkg::*;

    localparam int AW  = $clog2(MAX_WIDTH*MAX_HEIGHT);
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WDW = $clog2(MAX_WIDTH+1);
    localparam int HDW = $clog2(MAX_HEIGHT+1);
    localparam int STEP_W = PROD_W - GAIN_SHIFT;
    localparam int SUM_W  = STEP_W + 1;

    typedef enum logic [11:0] {
        E_IDLE     = 12'b0000_0000_0001,
        E_ROW_A    = 12'b0000_0000_0010,
        E_ROW_B    = 12'b0000_0000_0100,
        E_ROW_C    = 12'b0000_0000_1000,
        E_PX_R     = 12'b0000_0001_0000,
        E_PX_D     = 12'b0000_0010_0000,
        E_PX_U     = 12'b0000_0100_0000,
        E_PX_LAP   = 12'b0000_1000_0000,
        E_PX_MUL   = 12'b0001_0000_0000,
        E_PX_WB    = 12'b0010_0000_0000,
        E_PASS_END = 12'b0100_0000_0000,
        E_DONE     = 12'b1000_0000_0000
    } eng_state_t;

    eng_state_t state_reg, state_next;

    logic [RW-1:0]    row_reg;
    logic [CW-1:0]    col_reg;
    logic [AW-1:0]    base_reg;
    logic [CNT_W-1:0] pass_reg;
    logic             changed_reg;

    logic signed [SAMPLE_W-1:0] left_reg, center_reg, right_reg, down_reg;
    logic signed [LAP_W-1:0]    lap_reg;
    logic signed [PROD_W-1:0]   prod_reg;

    logic [SAMPLE_W-1:0]        old_rdata;
    logic signed [SAMPLE_W-1:0] frd, up_v;
    logic signed [LAP_W-1:0]    lap_sum;
    logic signed [STEP_W-1:0]   step;
    logic signed [SUM_W-1:0]    sum;
    logic signed [SAMPLE_W-1:0] nv;
    logic [AW-1:0]              w_a, row_off, col_add;
    logic                       row_end, last_row, first_row;

    assign w_a       = AW'(width);
    assign frd       = $signed(frame_rdata);
    assign row_end   = (col_reg == CW'(width - WDW'(2)));
    assign last_row  = (row_reg == RW'(height - HDW'(2)));
    assign first_row = (row_reg == RW'(1));

    // old copy of the row above, one entry per column
    idd_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_WIDTH)
    ) u_old_row (
        .clk   (aclk),
        .we    (state_reg == E_PX_WB),
        .waddr (col_reg),
        .wdata (center_reg),
        .raddr (col_reg),
        .rdata (old_rdata)
    );

    always_comb begin
        row_off = base_reg;
        col_add = AW'(col_reg);
        case (state_reg)
            E_ROW_A: begin
                col_add = '0;
            end
            E_ROW_B: begin
                col_add = AW'(1);
            end
            E_PX_R: begin
                col_add = AW'(col_reg) + AW'(1);
            end
            E_PX_D: begin
                row_off = base_reg + w_a;
            end
            E_PX_U: begin
                row_off = base_reg - w_a;
            end
            default: begin
            end
        endcase
        frame_raddr = row_off + col_add;
    end

    // row zero is a border and never rewritten, so it serves as its own old copy
    assign up_v    = first_row ? frd : $signed(old_rdata);
    assign lap_sum = LAP_W'(up_v) + LAP_W'(left_reg) + LAP_W'(right_reg) + LAP_W'(down_reg)
                   - (LAP_W'(center_reg) <<< CENTER_SHIFT);

    assign step = $signed(prod_reg[PROD_W-1:GAIN_SHIFT]);
    assign sum  = SUM_W'(center_reg) + SUM_W'(step);

    always_comb begin
        if (!sum[SUM_W-1] && (sum[SUM_W-2:SAMPLE_W-1] != '0)) begin
            nv = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end else if (sum[SUM_W-1] && (sum[SUM_W-2:SAMPLE_W-1] != '1)) begin
            nv = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            nv = sum[SAMPLE_W-1:0];
        end
    end

    assign frame_we    = (state_reg == E_PX_WB);
    assign frame_waddr = base_reg + AW'(col_reg);
    assign frame_wdata = nv;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            E_IDLE: begin
                if (start) begin
                    state_next = (passes == '0) ? E_DONE : E_ROW_A;
                end
            end
            E_ROW_A:  state_next = E_ROW_B;
            E_ROW_B:  state_next = E_ROW_C;
            E_ROW_C:  state_next = E_PX_R;
            E_PX_R:   state_next = E_PX_D;
            E_PX_D:   state_next = E_PX_U;
            E_PX_U:   state_next = E_PX_LAP;
            E_PX_LAP: state_next = E_PX_MUL;
            E_PX_MUL: state_next = E_PX_WB;
            E_PX_WB: begin
                if (!row_end) begin
                    state_next = E_PX_R;
                end else if (!last_row) begin
                    state_next = E_ROW_A;
                end else begin
                    state_next = E_PASS_END;
                end
            end
            E_PASS_END: begin
                // a pass that changed nothing settles the frame
                state_next = (changed_reg && pass_reg != CNT_W'(1)) ? E_ROW_A : E_DONE;
            end
            E_DONE:   state_next = E_IDLE;
            default:  state_next = E_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= E_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            E_IDLE: begin
                pass_reg    <= passes;
                row_reg     <= RW'(1);
                base_reg    <= w_a;
                changed_reg <= 1'b0;
            end
            E_ROW_B: begin
                left_reg <= frd;
            end
            E_ROW_C: begin
                center_reg <= frd;
                col_reg    <= CW'(1);
            end
            E_PX_D: begin
                right_reg <= frd;
            end
            E_PX_U: begin
                down_reg <= frd;
            end
            E_PX_LAP: begin
                lap_reg <= lap_sum;
            end
            E_PX_MUL: begin
                prod_reg <= lap_reg * $signed({1'b0, gain});
            end
            E_PX_WB: begin
                if (nv != center_reg) begin
                    changed_reg <= 1'b1;
                end
                left_reg   <= center_reg;
                center_reg <= right_reg;
                col_reg    <= col_reg + CW'(1);
                if (row_end) begin
                    row_reg  <= row_reg + RW'(1);
                    base_reg <= base_reg + w_a;
                end
            end
            E_PASS_END: begin
                pass_reg    <= pass_reg - CNT_W'(1);
                row_reg     <= RW'(1);
                base_reg    <= w_a;
                changed_reg <= 1'b0;
            end
            default: begin
            end
        endcase
    end

    assign stat.busy = (state_reg != E_IDLE);
    assign stat.done = (state_reg == E_DONE);

endmodule

// ===== design/isotropic_diffusion_denoise_top.sv =====
// isotropic_diffusion_denoise_top: frame store, load/readout control, result queue
// and apb registers; uses idd_pkg, idd_ram and idd_engine
//
// usage:
//   s_ channel takes one item per accepted handshake: s_tuser is the action
//   (load, run, read), s_tdata the pixel for a load. loads fill the frame store
//   in raster order, reads stream it back, one item per cycle sustained while the receiver keeps m_tready high.
//   m_ channel returns a readout pixel (m_tuser 0, m_tlast on the final pixel of
//   the frame) or a run-finished item (m_tuser 1, data zero).
//   a read result is registered through the frame-store read and the result queue before it shows on m_tvalid.
//   a run walks the frame interior once per executed pass:
//   each interior pixel costs six sequencer steps, set by three reads through
//   the single frame-store read port and the multiply stage; a pass that
//   changes no sample ends the run early.
//   a two-entry result queue lets input continue while a result waits; when the
//   receiver stalls the queue fills and s_tready drops.
//   s_tready stays low after each register write while the hold register clears.
//   reset sets the registers to their defaults, positions to zero and empties
//   the queue; the frame store is not cleared and has no clearing pass.
module isotropic_diffusion_denoise_top #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] pixel_in
    input  logic [1:0]                   s_tuser,   // [1:0] action
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [7:0]                   m_tdata,   // [7:0] pixel_out
    output logic                         m_tuser,   // [0] status
    output logic                         m_tlast,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [idd_pkg::APB_AW-1:0]   paddr,
    input  logic [idd_pkg::APB_DW-1:0]   pwdata,
    output logic [idd_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    import idd_pkg::*;

    localparam int AW  = $clog2(MAX_WIDTH*MAX_HEIGHT);
    localparam int PCW = $clog2(MAX_WIDTH*MAX_HEIGHT+1);
    localparam int WDW = $clog2(MAX_WIDTH+1);
    localparam int HDW = $clog2(MAX_HEIGHT+1);

    logic [GAIN_W-1:0]    gain_reg;
    logic [CNT_W-1:0]     passes_reg;
    logic [DIM_CFG_W-1:0] fw_reg, fh_reg;
    logic [1:0]           hold_reg;
    logic                 cfg_wr;

    logic [WDW-1:0] w_cl, w_cl_reg;
    logic [HDW-1:0] h_cl, h_cl_reg;
    logic [PCW-1:0] count_reg;

    logic [AW-1:0] load_pos_reg, read_pos_reg;
    logic [AW-1:0] load_eff, read_eff, load_next, read_next;
    logic          read_last;

    logic          accept, pop, push;
    logic          rd_pending_reg, rd_last_reg;
    logic [1:0]    q_cnt_reg, q_cnt_next;
    idd_result_t   q0_reg, q1_reg, push_data;
    logic [PIX_W-1:0] rd_pixel;

    idd_eng_stat_t       stat;
    logic [AW-1:0]       eng_raddr, eng_waddr, f_raddr, f_waddr;
    logic                eng_we, f_we;
    logic [SAMPLE_W-1:0] eng_wdata, f_wdata, f_rdata;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg   <= RST_GAIN;
            passes_reg <= RST_PASSES;
            fw_reg     <= RST_WIDTH;
            fh_reg     <= RST_HEIGHT;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_GAIN:   gain_reg   <= pwdata[GAIN_W-1:0];
                REG_PASSES: passes_reg <= pwdata[CNT_W-1:0];
                REG_WIDTH:  fw_reg     <= pwdata[DIM_CFG_W-1:0];
                REG_HEIGHT: fh_reg     <= pwdata[DIM_CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_GAIN:   prdata = APB_DW'(gain_reg);
            REG_PASSES: prdata = APB_DW'(passes_reg);
            REG_WIDTH:  prdata = APB_DW'(fw_reg);
            REG_HEIGHT: prdata = APB_DW'(fh_reg);
            default:    prdata = '0;
        endcase
    end

    // after a write, input is held while the frame size in use and pixel count settle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg <= 2'b11;
        end else if (cfg_wr) begin
            hold_reg <= 2'b11;
        end else begin
            hold_reg <= {1'b0, hold_reg[1]};
        end
    end

    always_comb begin
        if (fw_reg < DIM_CFG_W'(3)) begin
            w_cl = WDW'(3);
        end else if (32'(fw_reg) > MAX_WIDTH) begin
            w_cl = WDW'(MAX_WIDTH);
        end else begin
            w_cl = WDW'(fw_reg);
        end
        if (fh_reg < DIM_CFG_W'(3)) begin
            h_cl = HDW'(3);
        end else if (32'(fh_reg) > MAX_HEIGHT) begin
            h_cl = HDW'(MAX_HEIGHT);
        end else begin
            h_cl = HDW'(fh_reg);
        end
    end

    always_ff @(posedge aclk) begin
        w_cl_reg  <= w_cl;
        h_cl_reg  <= h_cl;
        count_reg <= PCW'(w_cl_reg) * PCW'(h_cl_reg);
    end

    // input channel
    assign pop      = m_tvalid & m_tready;
    assign s_tready = !stat.busy && (hold_reg == 2'b00)
                    && (((3'(q_cnt_reg) + 3'(rd_pending_reg)) <= 3'd1) || pop);
    assign accept   = s_tvalid & s_tready;

    // positions past the frame restart at pixel zero
    assign load_eff  = (PCW'(load_pos_reg) >= count_reg) ? '0 : load_pos_reg;
    assign load_next = ((PCW'(load_eff) + PCW'(1)) >= count_reg) ? '0 : load_eff + AW'(1);
    assign read_eff  = (PCW'(read_pos_reg) >= count_reg) ? '0 : read_pos_reg;
    assign read_last = ((PCW'(read_eff) + PCW'(1)) >= count_reg);
    assign read_next = read_last ? '0 : read_eff + AW'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_pos_reg   <= '0;
            read_pos_reg   <= '0;
            rd_pending_reg <= 1'b0;
        end else begin
            rd_pending_reg <= accept && (s_tuser == ACT_READ);
            if (accept) begin
                case (s_tuser)
                    ACT_LOAD: load_pos_reg <= load_next;
                    ACT_READ: read_pos_reg <= read_next;
                    ACT_RUN: begin
                        load_pos_reg <= '0;
                        read_pos_reg <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_last_reg <= read_last;
        end
    end

    // frame store, shared between load/readout and the pass engine
    assign f_we    = eng_we | (accept && (s_tuser == ACT_LOAD));
    assign f_waddr = stat.busy ? eng_waddr : load_eff;
    assign f_wdata = stat.busy ? eng_wdata : SAMPLE_W'({s_tdata, {FRAC_W{1'b0}}});
    assign f_raddr = stat.busy ? eng_raddr : read_eff;

    idd_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_WIDTH*MAX_HEIGHT)
    ) u_frame (
        .clk   (aclk),
        .we    (f_we),
        .waddr (f_waddr),
        .wdata (f_wdata),
        .raddr (f_raddr),
        .rdata (f_rdata)
    );

    idd_engine #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (accept && (s_tuser == ACT_RUN)),
        .gain        (gain_reg),
        .passes      (passes_reg),
        .width       (w_cl_reg),
        .height      (h_cl_reg),
        .stat        (stat),
        .frame_raddr (eng_raddr),
        .frame_rdata (f_rdata),
        .frame_we    (eng_we),
        .frame_waddr (eng_waddr),
        .frame_wdata (eng_wdata)
    );

    // readout: negative reads as zero, truncate the fraction, limit to 255
    always_comb begin
        if (f_rdata[SAMPLE_W-1]) begin
            rd_pixel = '0;
        end else if (f_rdata[SAMPLE_W-2:FRAC_W+PIX_W] != '0) begin
            rd_pixel = '1;
        end else begin
            rd_pixel = f_rdata[FRAC_W+PIX_W-1:FRAC_W];
        end
    end

    // result queue, two entries
    assign push = rd_pending_reg | stat.done;

    always_comb begin
        if (stat.done) begin
            push_data.pixel  = '0;
            push_data.status = 1'b1;
            push_data.last   = 1'b0;
        end else begin
            push_data.pixel  = rd_pixel;
            push_data.status = 1'b0;
            push_data.last   = rd_last_reg;
        end
    end

    assign q_cnt_next = q_cnt_reg + 2'(push) - 2'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_cnt_reg <= '0;
        end else begin
            q_cnt_reg <= q_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            q0_reg <= (q_cnt_reg == 2'd2) ? q1_reg : push_data;
            if (push && q_cnt_reg == 2'd2) begin
                q1_reg <= push_data;
            end
        end else if (push) begin
            if (q_cnt_reg == 2'd0) begin
                q0_reg <= push_data;
            end else begin
                q1_reg <= push_data;
            end
        end
    end

    assign m_tvalid = (q_cnt_reg != 2'd0);
    assign m_tdata  = q0_reg.pixel;
    assign m_tuser  = q0_reg.status;
    assign m_tlast  = q0_reg.last;

endmodule

// ===== design/idd_checker.sv =====
// idd_checker: port-level assertions for isotropic_diffusion_denoise_top
// bound to the top level below; uses idd_pkg
module idd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [1:0] s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser,
    input logic       m_tlast,
    input logic       psel,
    input logic       penable,
    input logic       pwrite
);
    import idd_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result changed while stalled");

    // run-finished item carries no pixel and no frame end
    a_done_fmt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (m_tdata == 8'd0) && !m_tlast)
        else $error("malformed run-finished item");

    // frame size settles before the next item is taken
    a_cfg_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable && pwrite |=> !s_tready)
        else $error("item taken right after a register write");

    // a run keeps the input closed while the engine works
    a_run_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == ACT_RUN) |=> !s_tready)
        else $error("item taken during a run");

endmodule

bind isotropic_diffusion_denoise_top idd_checker u_idd_checker (.*);
